// ----- sv/ray_triangle_closest_hit_defines.svh -----
// Assertion macros for the ray/triangle closest-hit block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH
`ifndef SYNTH
`define RTC_ASSERT(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("rtc check failed");
`define RTC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rtc check failed");
`define RTC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rtc check failed");
`else
`define RTC_ASSERT(name, clk, rstn, expr)
`define RTC_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RTC_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/rtc_pkg.sv -----
// Shared types, constants and column tables for the ray/triangle tester.
// Used by rtc_ctrl, rtc_dp and ray_triangle_closest_hit; no dependencies.
package rtc_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned ID_WIDTH  = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned BARY_BITS = 16;
  localparam int unsigned BARY_W    = 16;
  localparam int unsigned DIST_W    = 31;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned MULA_W    = 2 * MAG_W;
  localparam int unsigned PP_W      = MULA_W + CHUNK_W;
  localparam int unsigned PROD_W    = 3 * MAG_W;
  localparam int unsigned DET_W     = PROD_W + 5;
  localparam int unsigned DMAG_W    = DET_W - 1;
  localparam int unsigned QBITS     = DIST_W;
  localparam int unsigned DIV_W     = DMAG_W + QBITS;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAXD  = 3'd6;

  localparam logic [COORD_W-1:0] DIR_Z_RST = 32'h0001_0000;

  // determinant selects
  localparam logic [1:0] DET_A = 2'd0;
  localparam logic [1:0] DET_B = 2'd1;
  localparam logic [1:0] DET_G = 2'd2;
  localparam logic [1:0] DET_T = 2'd3;

  // column vectors
  localparam logic [1:0] COL_AB = 2'd0;
  localparam logic [1:0] COL_AC = 2'd1;
  localparam logic [1:0] COL_AO = 2'd2;
  localparam logic [1:0] COL_D  = 2'd3;

  localparam logic [2:0] LAST_TERM = 3'd5;

  typedef struct packed {
    logic       load;
    logic       term_ld;
    logic       mul_step;
    logic       mul_chunk;
    logic       mul_next;
    logic       acc;
    logic [1:0] det_sel;
    logic [2:0] term_sel;
    logic       norm;
    logic       div_ld;
    logic [1:0] div_sel;
    logic       div_step;
    logic       keep_t;
    logic       keep_b;
    logic       keep_g;
    logic       result;
    logic       hit;
  } rtc_cmd_t;

  typedef struct packed {
    logic pass;
    logic tq_ok;
    logic out_free;
  } rtc_stat_t;

  // column k of the matrix for each determinant
  function automatic logic [1:0] det_col(input logic [1:0] det, input logic [1:0] k);
    logic [1:0] c;
    c = COL_D;
    case (det)
      DET_A:   c = (k == 2'd0) ? COL_AB : (k == 2'd1) ? COL_AC : COL_D;
      DET_B:   c = (k == 2'd0) ? COL_AO : (k == 2'd1) ? COL_AC : COL_D;
      DET_G:   c = (k == 2'd0) ? COL_AB : (k == 2'd1) ? COL_AO : COL_D;
      default: c = (k == 2'd0) ? COL_AB : (k == 2'd1) ? COL_AC : COL_AO;
    endcase
    return c;
  endfunction

  // which column feeds row pos of a term; terms 3..5 are subtracted
  function automatic logic [1:0] term_pick(input logic [2:0] term, input logic [1:0] pos);
    logic [1:0] k;
    k = 2'd0;
    case (term)
      3'd0:    k = (pos == 2'd0) ? 2'd0 : (pos == 2'd1) ? 2'd1 : 2'd2;
      3'd1:    k = (pos == 2'd0) ? 2'd1 : (pos == 2'd1) ? 2'd2 : 2'd0;
      3'd2:    k = (pos == 2'd0) ? 2'd2 : (pos == 2'd1) ? 2'd0 : 2'd1;
      3'd3:    k = (pos == 2'd0) ? 2'd2 : (pos == 2'd1) ? 2'd1 : 2'd0;
      3'd4:    k = (pos == 2'd0) ? 2'd1 : (pos == 2'd1) ? 2'd0 : 2'd2;
      default: k = (pos == 2'd0) ? 2'd0 : (pos == 2'd1) ? 2'd2 : 2'd1;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/rtc_dp.sv -----
// Datapath: ray registers, edge vectors, shared 64x16 multiplier,
// determinant accumulators, restoring divider and output register. Uses rtc_pkg.
module rtc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rtc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                new_ray_i,
  input  logic [rtc_pkg::ID_W-1:0]            tri_id_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_a_x_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_a_y_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_a_z_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_b_x_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_b_y_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_b_z_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_c_x_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_c_y_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_c_z_i,
  input  rtc_pkg::rtc_cmd_t                   cmd_i,
  output rtc_pkg::rtc_stat_t                  stat_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                hit_o,
  output logic [rtc_pkg::ID_W-1:0]            hit_id_o,
  output logic [rtc_pkg::DIST_W-1:0]          hit_dist_o,
  output logic [rtc_pkg::BARY_W-1:0]          hit_beta_o,
  output logic [rtc_pkg::BARY_W-1:0]          hit_gamma_o
);

  localparam int unsigned DIFF_W = rtc_pkg::DIFF_W;
  localparam int unsigned DET_W  = rtc_pkg::DET_W;
  localparam int unsigned DMAG_W = rtc_pkg::DMAG_W;
  localparam int unsigned DIV_W  = rtc_pkg::DIV_W;
  localparam int unsigned PROD_W = rtc_pkg::PROD_W;
  localparam int unsigned MAG_W  = rtc_pkg::MAG_W;
  localparam int unsigned MULA_W = rtc_pkg::MULA_W;
  localparam int unsigned CHUNK_W = rtc_pkg::CHUNK_W;
  localparam int unsigned QBITS  = rtc_pkg::QBITS;

  logic signed [rtc_pkg::COORD_W-1:0] org_q [3];
  logic signed [rtc_pkg::COORD_W-1:0] dir_q [3];
  logic [rtc_pkg::DIST_W-1:0]         maxd_q;
  logic [rtc_pkg::DIST_W-1:0]         near_q;

  logic signed [DIFF_W-1:0] ab_q [3];
  logic signed [DIFF_W-1:0] ac_q [3];
  logic signed [DIFF_W-1:0] ao_q [3];
  logic [rtc_pkg::ID_W-1:0] id_q;

  logic signed [DIFF_W-1:0] va [3];
  logic signed [DIFF_W-1:0] vb [3];
  logic signed [DIFF_W-1:0] vc [3];
  logic signed [DIFF_W-1:0] cols [4][3];
  logic signed [DIFF_W-1:0] xv, yv, zv;

  logic [MULA_W-1:0]  mul_a_q;
  logic [MAG_W-1:0]   mul_b_q;
  logic [MAG_W-1:0]   mul_z_q;
  logic [PROD_W-1:0]  prod_q;
  logic               neg_q;
  logic [rtc_pkg::PP_W-1:0] pp;
  logic [PROD_W-1:0]  pp_sh;

  logic signed [DET_W-1:0] det_q [4];
  logic signed [DET_W-1:0] prod_ext;
  logic signed [DET_W:0]   bg_sum;

  logic [DIV_W-1:0]            rem_q, dsh_q;
  logic [QBITS-1:0]            q_q;
  logic                        sat_q;
  logic [DMAG_W-1:0]           num_mag, da_mag, dt_mag;
  logic [rtc_pkg::DIST_W-1:0]  tq;
  logic [rtc_pkg::DIST_W-1:0]  t_q;
  logic [rtc_pkg::BARY_W-1:0]  beta_q, gamma_q;
  logic                        out_valid_q;

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        dir_q[k] <= '0;
      end
      dir_q[2] <= rtc_pkg::DIR_Z_RST;
      maxd_q   <= rtc_pkg::DIST_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtc_pkg::REG_ORG_X: org_q[0] <= cfg_data_i;
        rtc_pkg::REG_ORG_Y: org_q[1] <= cfg_data_i;
        rtc_pkg::REG_ORG_Z: org_q[2] <= cfg_data_i;
        rtc_pkg::REG_DIR_X: dir_q[0] <= cfg_data_i;
        rtc_pkg::REG_DIR_Y: dir_q[1] <= cfg_data_i;
        rtc_pkg::REG_DIR_Z: dir_q[2] <= cfg_data_i;
        rtc_pkg::REG_MAXD:  maxd_q   <= cfg_data_i[rtc_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    va[0] = DIFF_W'(vert_a_x_i); va[1] = DIFF_W'(vert_a_y_i); va[2] = DIFF_W'(vert_a_z_i);
    vb[0] = DIFF_W'(vert_b_x_i); vb[1] = DIFF_W'(vert_b_y_i); vb[2] = DIFF_W'(vert_b_z_i);
    vc[0] = DIFF_W'(vert_c_x_i); vc[1] = DIFF_W'(vert_c_y_i); vc[2] = DIFF_W'(vert_c_z_i);
    for (int k = 0; k < 3; k++) begin
      cols[rtc_pkg::COL_AB][k] = ab_q[k];
      cols[rtc_pkg::COL_AC][k] = ac_q[k];
      cols[rtc_pkg::COL_AO][k] = ao_q[k];
      cols[rtc_pkg::COL_D][k]  = DIFF_W'(dir_q[k]);
    end
    xv = cols[rtc_pkg::det_col(cmd_i.det_sel, rtc_pkg::term_pick(cmd_i.term_sel, 2'd0))][0];
    yv = cols[rtc_pkg::det_col(cmd_i.det_sel, rtc_pkg::term_pick(cmd_i.term_sel, 2'd1))][1];
    zv = cols[rtc_pkg::det_col(cmd_i.det_sel, rtc_pkg::term_pick(cmd_i.term_sel, 2'd2))][2];
  end

  // item capture: edge vectors and identifier
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 3; k++) begin
        ab_q[k] <= va[k] - vb[k];
        ac_q[k] <= va[k] - vc[k];
        ao_q[k] <= va[k] - DIFF_W'(org_q[k]);
      end
      id_q <= tri_id_i & rtc_pkg::ID_W'({rtc_pkg::ID_WIDTH{1'b1}});
    end
  end

  // shared multiplier: two 16-bit chunks per product, magnitude times magnitude
  always_comb begin
    pp    = mul_a_q * (cmd_i.mul_chunk ? mul_b_q[MAG_W-1:CHUNK_W] : mul_b_q[CHUNK_W-1:0]);
    pp_sh = cmd_i.mul_chunk ? PROD_W'({pp, {CHUNK_W{1'b0}}}) : PROD_W'(pp);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.term_ld) begin
      mul_a_q <= MULA_W'(mag(xv));
      mul_b_q <= mag(yv);
      mul_z_q <= mag(zv);
      neg_q   <= xv[DIFF_W-1] ^ yv[DIFF_W-1] ^ zv[DIFF_W-1] ^ (cmd_i.term_sel > 3'd2);
      prod_q  <= '0;
    end else if (cmd_i.mul_next) begin
      mul_a_q <= prod_q[MULA_W-1:0];
      mul_b_q <= mul_z_q;
      prod_q  <= '0;
    end else if (cmd_i.mul_step) begin
      prod_q  <= prod_q + pp_sh;
    end
  end

  // determinant accumulation and sign normalization
  assign prod_ext = $signed({{(DET_W-PROD_W){1'b0}}, prod_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 4; k++) det_q[k] <= '0;
    end else if (cmd_i.acc) begin
      det_q[cmd_i.det_sel] <= neg_q ? det_q[cmd_i.det_sel] - prod_ext
                                    : det_q[cmd_i.det_sel] + prod_ext;
    end else if (cmd_i.norm && det_q[rtc_pkg::DET_A][DET_W-1]) begin
      for (int k = 0; k < 4; k++) det_q[k] <= -det_q[k];
    end
  end

  assign bg_sum = (DET_W+1)'(det_q[rtc_pkg::DET_B]) + (DET_W+1)'(det_q[rtc_pkg::DET_G]);

  assign stat_o.pass = (det_q[rtc_pkg::DET_A] != '0) && (det_q[rtc_pkg::DET_B] > 0) &&
                       (det_q[rtc_pkg::DET_G] > 0) && (det_q[rtc_pkg::DET_T] > 0) &&
                       (bg_sum < (DET_W+1)'(det_q[rtc_pkg::DET_A]));

  // restoring divider, one quotient bit per cycle
  assign num_mag = det_q[cmd_i.div_sel][DMAG_W-1:0];
  assign da_mag  = det_q[rtc_pkg::DET_A][DMAG_W-1:0];
  assign dt_mag  = det_q[rtc_pkg::DET_T][DMAG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld) begin
      rem_q <= (cmd_i.div_sel == rtc_pkg::DET_T) ? (DIV_W'(num_mag) << rtc_pkg::FRAC_BITS)
                                                  : (DIV_W'(num_mag) << rtc_pkg::BARY_BITS);
      dsh_q <= DIV_W'(da_mag) << (QBITS - 1);
      sat_q <= (DIV_W'(dt_mag) << rtc_pkg::FRAC_BITS) >= (DIV_W'(da_mag) << QBITS);
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        q_q   <= {q_q[QBITS-2:0], 1'b1};
      end else begin
        q_q   <= {q_q[QBITS-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign tq           = sat_q ? rtc_pkg::DIST_MAX : q_q;
  assign stat_o.tq_ok = (tq != '0) && (tq < near_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep_t) t_q     <= tq;
    if (cmd_i.keep_b) beta_q  <= q_q[rtc_pkg::BARY_W-1:0];
    if (cmd_i.keep_g) gamma_q <= q_q[rtc_pkg::BARY_W-1:0];
  end

  // nearest distance and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q      <= rtc_pkg::DIST_MAX;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && new_ray_i) near_q <= maxd_q;
      else if (cmd_i.result && cmd_i.hit) near_q <= t_q;
      if (cmd_i.result) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      hit_o       <= cmd_i.hit;
      hit_id_o    <= id_q;
      hit_dist_o  <= cmd_i.hit ? t_q : '0;
      hit_beta_o  <= cmd_i.hit ? beta_q : '0;
      hit_gamma_o <= cmd_i.hit ? gamma_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ----- sv/rtc_ctrl.sv -----
// Controller: sequences the 24 determinant terms, sign fixup, the three
// divisions and the result transfer. Uses rtc_pkg and the assertion macros.
`include "ray_triangle_closest_hit_defines.svh"
module rtc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rtc_pkg::rtc_stat_t stat_i,
  output rtc_pkg::rtc_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TERM   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_NORM   = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_DIVEND = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  localparam logic [4:0] MUL_NEXT = 5'd2;
  localparam logic [4:0] MUL_LAST = 5'd4;
  localparam logic [4:0] DIV_LAST = 5'(rtc_pkg::QBITS - 1);

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] det_q, det_d;
  logic [2:0] term_q, term_d;
  logic [1:0] dsel_q, dsel_d;
  logic       hit_q, hit_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    det_d   = det_q;
    term_d  = term_q;
    dsel_d  = dsel_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    cmd_o.det_sel  = det_q;
    cmd_o.term_sel = term_q;
    cmd_o.div_sel  = dsel_q;
    cmd_o.hit      = hit_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          det_d   = rtc_pkg::DET_A;
          term_d  = '0;
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        cmd_o.term_ld = 1'b1;
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (cnt_q == MUL_NEXT) cmd_o.mul_next = 1'b1;
        else cmd_o.mul_step = 1'b1;
        cmd_o.mul_chunk = (cnt_q == 5'd1) || (cnt_q == MUL_LAST);
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == MUL_LAST) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_TERM;
        if (term_q == rtc_pkg::LAST_TERM) begin
          term_d = '0;
          if (det_q == rtc_pkg::DET_T) state_d = S_NORM;
          else det_d = det_q + 2'd1;
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.pass) begin
          cmd_o.div_ld  = 1'b1;
          cmd_o.div_sel = rtc_pkg::DET_T;
          dsel_d  = rtc_pkg::DET_T;
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          hit_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) state_d = S_DIVEND;
      end
      S_DIVEND: begin
        cnt_d = '0;
        case (dsel_q)
          rtc_pkg::DET_T: begin
            cmd_o.keep_t = 1'b1;
            if (stat_i.tq_ok) begin
              cmd_o.div_ld  = 1'b1;
              cmd_o.div_sel = rtc_pkg::DET_B;
              dsel_d  = rtc_pkg::DET_B;
              state_d = S_DIV;
            end else begin
              hit_d   = 1'b0;
              state_d = S_DONE;
            end
          end
          rtc_pkg::DET_B: begin
            cmd_o.keep_b  = 1'b1;
            cmd_o.div_ld  = 1'b1;
            cmd_o.div_sel = rtc_pkg::DET_G;
            dsel_d  = rtc_pkg::DET_G;
            state_d = S_DIV;
          end
          default: begin
            cmd_o.keep_g = 1'b1;
            hit_d   = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.result = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      det_q   <= rtc_pkg::DET_A;
      term_q  <= '0;
      dsel_q  <= rtc_pkg::DET_T;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      det_q   <= det_d;
      term_q  <= term_d;
      dsel_q  <= dsel_d;
      hit_q   <= hit_d;
    end
  end

  `RTC_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_TERM)
  `RTC_ASSERT_IMP(a_result_free, clk_i, rst_ni, cmd_o.result, stat_i.out_free)
  `RTC_ASSERT_IMP(a_div_count, clk_i, rst_ni, state_q == S_DIV, cnt_q <= DIV_LAST)
  `RTC_ASSERT_IMP(a_mul_count, clk_i, rst_ni, state_q == S_MUL, cnt_q <= MUL_LAST)

endmodule

// ----- sv/ray_triangle_closest_hit.sv -----
// Ray/triangle closest-hit tester, top level.
// Input channel: one triangle per transfer (new_ray flag, id, three vertices),
// valid/stall handshake; in_stall_o is high while an item is in progress.
// Output channel: one result per triangle (hit flag, id, distance, beta, gamma)
// from an output register; distance and barycentrics read zero on a miss.
// Configuration: write port cfg_we_i/cfg_idx_i/cfg_data_i, registers 0..6 are
// origin x/y/z, direction x/y/z and maximum distance; write only when idle.
// Sequence: each of the 24 determinant terms runs on the shared 64x16
// multiplier (load, four multiply steps and one transfer, accumulate); the
// sign tests follow the accepting cycle, all terms and the sign fixup. A passing
// triangle then needs a restoring division for t and, if it is the new
// nearest, two more for beta and gamma. The result is then loaded into the
// output register, one item at a time.
// The next item is taken while the previous result still waits.
// Reset: ray origin 0, direction +z, maximum and nearest distance saturated.
// A stalled output holds its result; the block then waits before loading the
// next one.
module ray_triangle_closest_hit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rtc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                new_ray_i,
  input  logic [rtc_pkg::ID_W-1:0]            tri_id_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_a_x_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_a_y_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_a_z_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_b_x_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_b_y_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_b_z_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_c_x_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_c_y_i,
  input  logic signed [rtc_pkg::COORD_W-1:0]  vert_c_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [rtc_pkg::ID_W-1:0]            hit_id_o,
  output logic [rtc_pkg::DIST_W-1:0]          hit_dist_o,
  output logic [rtc_pkg::BARY_W-1:0]          hit_beta_o,
  output logic [rtc_pkg::BARY_W-1:0]          hit_gamma_o
);

  rtc_pkg::rtc_cmd_t  cmd;
  rtc_pkg::rtc_stat_t stat;

  rtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rtc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .new_ray_i   (new_ray_i),
    .tri_id_i    (tri_id_i),
    .vert_a_x_i  (vert_a_x_i),
    .vert_a_y_i  (vert_a_y_i),
    .vert_a_z_i  (vert_a_z_i),
    .vert_b_x_i  (vert_b_x_i),
    .vert_b_y_i  (vert_b_y_i),
    .vert_b_z_i  (vert_b_z_i),
    .vert_c_x_i  (vert_c_x_i),
    .vert_c_y_i  (vert_c_y_i),
    .vert_c_z_i  (vert_c_z_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .hit_o       (hit_o),
    .hit_id_o    (hit_id_o),
    .hit_dist_o  (hit_dist_o),
    .hit_beta_o  (hit_beta_o),
    .hit_gamma_o (hit_gamma_o)
  );

endmodule
